@@ rtl/core/adc_pkg.sv @@
`timescale 1ns / 1ps

package adc_pkg;

    localparam int SPD_W = 16;
    localparam int RHO_W = 20;
    localparam int PRS_W = 17;
    localparam int TMP_W = 16;
    localparam int REF_W = 16;

    localparam int PM5_W     = 34;
    localparam int DEN_RHO_W = 35;
    localparam int NUM_RHO_W = 51;
    localparam int RN_W      = 35;
    localparam int N_RAT_W   = 51;
    localparam int D_RAT_W   = 47;
    // N < D * 2^RAT_INT_W for every legal item
    localparam int RAT_INT_W = 21;

    localparam logic [18:0]        GAS_MILLI    = 19'd287058;
    localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
    localparam logic [16:0]        DEC5         = 17'd100000;
    localparam logic [29:0]        DEC9         = 30'd1000000000;
    localparam logic [REF_W-1:0]   REF_RESET    = 16'd12250;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SAT     = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic             cmd;
        logic [SPD_W-1:0] speed;
        logic [PRS_W-1:0] pres;
        logic [TMP_W-1:0] temp;
    } t_in_item;

    typedef struct packed {
        logic             cmd;
        logic [SPD_W-1:0] speed;
        logic             inval;
    } t_item;

endpackage

@@ rtl/core/adc_front.sv @@
`timescale 1ns / 1ps

module adc_front import adc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_in_item             i_item,
    input  logic [REF_W-1:0]     i_ref,
    output logic                 o_valid,
    output t_item                o_item,
    output logic [NUM_RHO_W-1:0] o_num_rho,
    output logic [DEN_RHO_W-1:0] o_den_rho,
    output logic [N_RAT_W-1:0]   o_n_ratio,
    output logic [D_RAT_W-1:0]   o_d_ratio
);

    logic [3:1] r_v;

    t_item                r1_item;
    logic [15:0]          r1_tk;
    logic [PM5_W-1:0]     r1_pm5;
    logic [DEN_RHO_W-1:0] r1_den;
    logic [RN_W-1:0]      r1_rn;
    logic [D_RAT_W-1:0]   r1_d;

    t_item                r2_item;
    logic [NUM_RHO_W-1:0] r2_num;
    logic [DEN_RHO_W-1:0] r2_den;
    logic [N_RAT_W-1:0]   r2_n;
    logic [D_RAT_W-1:0]   r2_d;

    t_item                r3_item;
    logic [NUM_RHO_W-1:0] r3_num;
    logic [DEN_RHO_W-1:0] r3_den;
    logic [N_RAT_W-1:0]   r3_n;
    logic [D_RAT_W-1:0]   r3_d;

    logic signed [16:0]   tk_s;
    t_item                n1_item;

    always_comb begin
        tk_s          = $signed({i_item.temp[TMP_W-1], i_item.temp}) + KELVIN_CENTI;
        n1_item.cmd   = i_item.cmd;
        n1_item.speed = i_item.speed;
        n1_item.inval = (i_item.pres == '0) || (tk_s <= 17'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_item <= n1_item;
            r1_tk   <= tk_s[15:0];
            r1_pm5  <= PM5_W'(i_item.pres) * PM5_W'(DEC5);
            r1_den  <= DEN_RHO_W'(tk_s[15:0]) * DEN_RHO_W'(GAS_MILLI);
            r1_rn   <= RN_W'(i_ref) * RN_W'(GAS_MILLI);
            r1_d    <= D_RAT_W'(i_item.pres) * D_RAT_W'(DEC9);

            r2_item <= r1_item;
            r2_num  <= NUM_RHO_W'(r1_pm5) * NUM_RHO_W'(DEC5);
            r2_den  <= r1_den;
            r2_n    <= N_RAT_W'(r1_rn) * N_RAT_W'(r1_tk);
            r2_d    <= r1_d;

            r3_item <= r2_item;
            r3_num  <= r2_num + NUM_RHO_W'(r2_den >> 1);
            r3_den  <= r2_den;
            r3_n    <= r2_n;
            r3_d    <= r2_d;
        end
    end

    assign o_valid   = r_v[3];
    assign o_item    = r3_item;
    assign o_num_rho = r3_num;
    assign o_den_rho = r3_den;
    assign o_n_ratio = r3_n;
    assign o_d_ratio = r3_d;

endmodule

@@ rtl/core/adc_pdiv.sv @@
`timescale 1ns / 1ps

module adc_pdiv #(
    parameter int NW = 51,
    parameter int DW = 35,
    parameter int QW = 20,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [QW:0]   r_v;
    logic [DW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_low  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic          r_ovf  [0:QW];
    logic [SW-1:0] r_side [0:QW];

    logic [QW:0]   n_v;
    logic [DW-1:0] n_rem  [0:QW];
    logic [DW-1:0] n_den  [0:QW];
    logic [QW-1:0] n_low  [0:QW];
    logic [QW-1:0] n_q    [0:QW];
    logic          n_ovf  [0:QW];
    logic [SW-1:0] n_side [0:QW];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        n_v[0]    = i_valid;
        n_rem[0]  = DW'(i_num[NW-1:QW]);
        n_den[0]  = i_den;
        n_low[0]  = i_num[QW-1:0];
        n_q[0]    = '0;
        n_ovf[0]  = CW'(i_num[NW-1:QW]) >= CW'(i_den);
        n_side[0] = i_side;
        for (int k = 1; k <= QW; k++) begin
            t         = {r_rem[k-1], r_low[k-1][QW-1]};
            ge        = t >= {1'b0, r_den[k-1]};
            n_v[k]    = r_v[k-1];
            n_rem[k]  = ge ? DW'(t - {1'b0, r_den[k-1]}) : DW'(t);
            n_den[k]  = r_den[k-1];
            n_low[k]  = r_low[k-1] << 1;
            n_q[k]    = {r_q[k-1][QW-2:0], ge};
            n_ovf[k]  = r_ovf[k-1];
            n_side[k] = r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= n_den;
            r_low  <= n_low;
            r_q    <= n_q;
            r_ovf  <= n_ovf;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[QW];
    assign o_quot  = r_q[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_side  = r_side[QW];

endmodule

@@ rtl/core/adc_psqrt.sv @@
`timescale 1ns / 1ps

module adc_psqrt #(
    parameter int RW = 27,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int XW = 2 * RW;
    localparam int MW = RW + 2;

    logic [RW:0]   r_v;
    logic [XW-1:0] r_x    [0:RW];
    logic [MW-1:0] r_srem [0:RW];
    logic [RW-1:0] r_root [0:RW];
    logic [SW-1:0] r_side [0:RW];

    logic [RW:0]   n_v;
    logic [XW-1:0] n_x    [0:RW];
    logic [MW-1:0] n_srem [0:RW];
    logic [RW-1:0] n_root [0:RW];
    logic [SW-1:0] n_side [0:RW];

    always_comb begin
        logic [MW+1:0] t;
        logic [MW+1:0] trial;
        logic          ge;
        n_v[0]    = i_valid;
        n_x[0]    = i_x;
        n_srem[0] = '0;
        n_root[0] = '0;
        n_side[0] = i_side;
        for (int k = 1; k <= RW; k++) begin
            t         = {r_srem[k-1], r_x[k-1][XW-1:XW-2]};
            trial     = (MW+2)'({r_root[k-1], 2'b01});
            ge        = t >= trial;
            n_v[k]    = r_v[k-1];
            n_x[k]    = r_x[k-1] << 2;
            n_srem[k] = ge ? MW'(t - trial) : MW'(t);
            n_root[k] = {r_root[k-1][RW-2:0], ge};
            n_side[k] = r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_srem <= n_srem;
            r_root <= n_root;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

@@ rtl/core/airspeed_density_correction_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake                    | Payload
// ---------+------------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready      | i_cmd, i_speed_in, i_static_pressure,
//          |                              | i_air_temp
// out      | o_out_valid / i_out_ready    | o_speed_out, o_density_out, o_status
// cfg      | i_cfg_valid / o_cfg_ready    | i_cfg_data (reference density)
//
// One item per cycle while the output is not stalled. Items pass through the front stages,
// the bit-per-stage dividers (density, ratio, speed) and the root-per-stage square root.
// Synchronous active-low reset clears all valid bits and loads reference density 12250.
// A stall at the output freezes the whole pipeline; one input skid register
// takes a single item during the stall, then o_in_ready stays low until the stall ends.

module airspeed_density_correction_unit import adc_pkg::*; #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  logic [SPD_W-1:0] i_speed_in,
    input  logic [PRS_W-1:0] i_static_pressure,
    input  logic [TMP_W-1:0] i_air_temp,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [SPD_W-1:0] o_speed_out,
    output logic [RHO_W-1:0] o_density_out,
    output logic [1:0]       o_status,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [REF_W-1:0] i_cfg_data
);

    localparam int F    = RATIO_FRAC_BITS;
    localparam int RQW  = RAT_INT_W + 2 * F;
    localparam int RNW  = N_RAT_W + 2 * F;
    localparam int RTW  = (RQW + 1) / 2;
    localparam int PW   = SPD_W + RTW + 1;
    localparam int SNW  = SPD_W + F + 1;
    localparam int IW   = $bits(t_item);
    localparam int SW1  = IW + N_RAT_W + D_RAT_W;
    localparam int SW2  = IW + RHO_W + 1;
    localparam int SW3  = IW + RHO_W + 1 + 1 + SPD_W + 1;
    localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

    logic             en;
    logic [REF_W-1:0] r_ref;
    logic             r_sk_v;
    t_in_item         r_sk;
    t_in_item         in_item;

    logic                 f_v;
    t_item                f_item;
    logic [NUM_RHO_W-1:0] f_num;
    logic [DEN_RHO_W-1:0] f_den;
    logic [N_RAT_W-1:0]   f_n;
    logic [D_RAT_W-1:0]   f_d;

    logic               d1_v;
    logic [RHO_W-1:0]   d1_q;
    logic               d1_ovf;
    logic [SW1-1:0]     d1_side;
    t_item              d1_item;
    logic [N_RAT_W-1:0] d1_n;
    logic [D_RAT_W-1:0] d1_d;

    logic             d2_v;
    logic [RQW-1:0]   d2_q;
    logic             d2_ovf;
    logic [SW2-1:0]   d2_side;

    logic             sq_v;
    logic [RTW-1:0]   sq_s;
    logic [SW2-1:0]   sq_side;
    t_item            sq_item;
    logic [RHO_W-1:0] sq_rho;
    logic             sq_rovf;
    logic [PW-1:0]    prod;

    logic             r_m_v;
    t_item            r_m_item;
    logic [RHO_W-1:0] r_m_rho;
    logic             r_m_rovf;
    logic             r_m_szero;
    logic [SPD_W-1:0] r_m_v0;
    logic             r_m_v0sat;
    logic [SNW-1:0]   r_m_numer;
    logic [RTW-1:0]   r_m_s;

    logic             d3_v;
    logic [SPD_W-1:0] d3_q;
    logic             d3_ovf;
    logic [SW3-1:0]   d3_side;
    t_item            d3_item;
    logic [RHO_W-1:0] d3_rho;
    logic             d3_rovf;
    logic             d3_szero;
    logic [SPD_W-1:0] d3_v0;
    logic             d3_v0sat;

    logic             r_out_v;
    logic [SPD_W-1:0] r_out_speed;
    logic [RHO_W-1:0] r_out_rho;
    t_status          r_out_status;
    logic [SPD_W-1:0] n_out_speed;
    logic [RHO_W-1:0] n_out_rho;
    t_status          n_out_status;

    assign en          = !r_out_v || i_out_ready;
    assign o_in_ready  = !r_sk_v;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET;
        end else if (i_cfg_valid) begin
            r_ref <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else begin
            r_sk_v <= en ? 1'b0 : (r_sk_v || i_in_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && !r_sk_v) begin
            r_sk <= '{cmd: i_cmd, speed: i_speed_in, pres: i_static_pressure,
                      temp: i_air_temp};
        end
    end

    always_comb begin
        if (r_sk_v) begin
            in_item = r_sk;
        end else begin
            in_item = '{cmd: i_cmd, speed: i_speed_in, pres: i_static_pressure,
                        temp: i_air_temp};
        end
    end

    adc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (r_sk_v || i_in_valid),
        .i_item    (in_item),
        .i_ref     (r_ref),
        .o_valid   (f_v),
        .o_item    (f_item),
        .o_num_rho (f_num),
        .o_den_rho (f_den),
        .o_n_ratio (f_n),
        .o_d_ratio (f_d)
    );

    adc_pdiv #(.NW(NUM_RHO_W), .DW(DEN_RHO_W), .QW(RHO_W), .SW(SW1)) u_div_rho (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  ({f_item, f_n, f_d}),
        .o_valid (d1_v),
        .o_quot  (d1_q),
        .o_ovf   (d1_ovf),
        .o_side  (d1_side)
    );

    assign {d1_item, d1_n, d1_d} = d1_side;

    adc_pdiv #(.NW(RNW), .DW(D_RAT_W), .QW(RQW), .SW(SW2)) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d1_v),
        .i_num   ({d1_n, {(2*F){1'b0}}}),
        .i_den   (d1_d),
        .i_side  ({d1_item, d1_q, d1_ovf}),
        .o_valid (d2_v),
        .o_quot  (d2_q),
        .o_ovf   (d2_ovf),
        .o_side  (d2_side)
    );

    adc_psqrt #(.RW(RTW), .SW(SW2)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d2_v),
        .i_x     ((2*RTW)'(d2_q)),
        .i_side  (d2_side),
        .o_valid (sq_v),
        .o_root  (sq_s),
        .o_side  (sq_side)
    );

    assign {sq_item, sq_rho, sq_rovf} = sq_side;
    assign prod = PW'(sq_item.speed) * PW'(sq_s) + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_item  <= sq_item;
            r_m_rho   <= sq_rho;
            r_m_rovf  <= sq_rovf;
            r_m_szero <= (sq_s == '0);
            r_m_v0    <= prod[F+SPD_W-1:F];
            r_m_v0sat <= |prod[PW-1:F+SPD_W];
            r_m_numer <= (SNW'(sq_item.speed) << F) + SNW'(sq_s >> 1);
            r_m_s     <= sq_s;
        end
    end

    adc_pdiv #(.NW(SNW), .DW(RTW), .QW(SPD_W), .SW(SW3)) u_div_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m_v),
        .i_num   (r_m_numer),
        .i_den   (r_m_s),
        .i_side  ({r_m_item, r_m_rho, r_m_rovf, r_m_szero, r_m_v0, r_m_v0sat}),
        .o_valid (d3_v),
        .o_quot  (d3_q),
        .o_ovf   (d3_ovf),
        .o_side  (d3_side)
    );

    assign {d3_item, d3_rho, d3_rovf, d3_szero, d3_v0, d3_v0sat} = d3_side;

    always_comb begin
        logic             vs;
        logic [SPD_W-1:0] v;
        if (!d3_item.cmd) begin
            v  = d3_v0;
            vs = d3_v0sat;
        end else if (d3_szero) begin
            v  = '0;
            vs = (d3_item.speed != '0);
        end else begin
            v  = d3_q;
            vs = d3_ovf;
        end
        if (d3_item.inval) begin
            n_out_speed  = '0;
            n_out_rho    = '0;
            n_out_status = ST_INVALID;
        end else begin
            n_out_speed  = vs ? '1 : v;
            n_out_rho    = d3_rovf ? '1 : d3_rho;
            n_out_status = (vs || d3_rovf) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_speed  <= n_out_speed;
            r_out_rho    <= n_out_rho;
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_speed_out   = r_out_speed;
    assign o_density_out = r_out_rho;
    assign o_status      = r_out_status;

endmodule

@@ rtl/core/adc_chk.sv @@
`timescale 1ns / 1ps

module adc_chk import adc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [SPD_W-1:0] o_speed_out,
    input logic [RHO_W-1:0] o_density_out,
    input logic [1:0]       o_status
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_SAT || o_status == ST_INVALID))
        else $error("bad status code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_INVALID) |-> (o_speed_out == '0 && o_density_out == '0))
        else $error("invalid item with nonzero result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_speed_out) && $stable(o_density_out) && $stable(o_status)))
        else $error("stalled item changed");

endmodule

bind airspeed_density_correction_unit adc_chk u_adc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_speed_out   (o_speed_out),
    .o_density_out (o_density_out),
    .o_status      (o_status)
);
